// File: design/ast_pkg.sv
package ast_pkg;

  // Fixed field widths
  localparam int unsigned NOW_W     = 48;
  localparam int unsigned HANDLE_W  = 5;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned AGE_W     = 29;
  localparam int unsigned OCC_OUT_W = 4;

  // Defaults of the top level parameters
  localparam int unsigned DEF_TABLE_SLOTS = 8;
  localparam int unsigned DEF_NUM_HANDLES = 32;
  localparam int unsigned DEF_TIME_BITS   = 48;

  localparam int unsigned REQ_QUEUE_DEPTH = 2;
  localparam int unsigned RES_QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] TICK_INTERVAL_RESET = CFG_W'(30_000_000);
  localparam logic [CFG_W-1:0] ACTIVE_WINDOW_RESET = CFG_W'(60_000_000);

  localparam int unsigned USEC_PER_SEC = 1_000_000;
  localparam int unsigned SEC_W        = 20;
  localparam logic [SEC_W-1:0] SEC_USEC = SEC_W'(USEC_PER_SEC);
  // floor(2^NOW_W / one second), fits in AGE_W bits
  localparam logic [AGE_W-1:0] SEC_RECIP = AGE_W'((64'd1 << NOW_W) / 64'(USEC_PER_SEC));

  typedef enum logic [REQ_W-1:0] {
    REQ_BEGIN = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_END   = 2'd2,
    REQ_QUERY = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    OP_BEGIN,
    OP_TICK,
    OP_END,
    OP_QUERY,
    OP_IGNORE
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_INTERVAL = 1'b0,
    CFG_ACTIVE_WINDOW = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_AGE,
    ST_DIV
  } st_e;

  typedef struct packed {
    op_e                 op;
    logic [HANDLE_W-1:0] handle;
    logic [NOW_W-1:0]    now;
  } req_t;

  typedef struct packed {
    logic [NOW_W-1:0] begin_time;
    logic [NOW_W-1:0] last_tick;
    logic [CNT_W-1:0] tick_cnt;
  } rec_t;

  typedef struct packed {
    logic                 emitted;
    logic                 registered;
    logic [NOW_W-1:0]     elapsed_us;
    logic [CNT_W-1:0]     tick_total;
    logic                 active;
    logic [AGE_W-1:0]     tick_age_sec;
    logic [HANDLE_W-1:0]  recent_handle;
    logic                 recent_found;
    logic [OCC_OUT_W-1:0] occupied_slots;
  } res_t;

endpackage

// File: design/ast_fifo.sv
module ast_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned DEPTH  = ast_pkg::REQ_QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: design/ast_sec_div.sv
module ast_sec_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ast_pkg::NOW_W-1:0]    num_i,
  output logic                         done_o,
  output logic [ast_pkg::AGE_W-1:0]    quot_o
);

  localparam int unsigned NOW_W  = ast_pkg::NOW_W;
  localparam int unsigned AGE_W  = ast_pkg::AGE_W;
  localparam int unsigned HALF_W = NOW_W / 2;
  localparam int unsigned PART_W = HALF_W + AGE_W;
  localparam int unsigned ACC_W  = NOW_W + AGE_W;
  localparam int unsigned QP_W   = AGE_W + ast_pkg::SEC_W;
  localparam int unsigned STAGES = 5;

  logic [STAGES-1:0]  stage_q;
  logic               done_q;
  logic [NOW_W-1:0]   num_q, rem_q;
  logic [PART_W-1:0]  phi_q, plo_q;
  logic [AGE_W-1:0]   quo_q;
  logic [ACC_W-1:0]   acc;
  logic [QP_W-1:0]    back_prod;

  // seconds by reciprocal multiply: the estimate is low by at most one,
  // the remainder check adds it back. One stage per cycle:
  // high half product, low half product, sum, remainder, correction.
  assign acc       = {phi_q, HALF_W'(0)} + ACC_W'(plo_q);
  assign back_prod = QP_W'(quo_q) * QP_W'(ast_pkg::SEC_USEC);
  assign done_o    = done_q;
  assign quot_o    = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= {stage_q[STAGES-2:0], start_i};
      done_q  <= stage_q[STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
    end
    if (stage_q[0]) begin
      phi_q <= PART_W'(num_q[NOW_W-1:HALF_W]) * PART_W'(ast_pkg::SEC_RECIP);
    end
    if (stage_q[1]) begin
      plo_q <= PART_W'(num_q[HALF_W-1:0]) * PART_W'(ast_pkg::SEC_RECIP);
    end
    if (stage_q[2]) begin
      quo_q <= acc[ACC_W-1:NOW_W];
    end
    if (stage_q[3]) begin
      rem_q <= num_q - back_prod[NOW_W-1:0];
    end
    if (stage_q[4]) begin
      quo_q <= quo_q + AGE_W'(rem_q >= NOW_W'(ast_pkg::SEC_USEC));
    end
  end

endmodule

// File: design/ast_front.sv
module ast_front #(
  parameter int unsigned NUM_HANDLES = ast_pkg::DEF_NUM_HANDLES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [ast_pkg::REQ_W-1:0]      req_type_i,
  input  logic [ast_pkg::HANDLE_W-1:0]   scope_handle_i,
  input  logic [ast_pkg::NOW_W-1:0]      now_us_i,
  output ast_pkg::req_t                  req_o,
  output logic                           req_valid_o,
  input  logic                           req_pop_i
);

  ast_pkg::req_t req_in;
  ast_pkg::op_e  op;
  logic          queue_empty;

  always_comb begin
    case (ast_pkg::req_type_e'(req_type_i))
      ast_pkg::REQ_BEGIN: op = ast_pkg::OP_BEGIN;
      ast_pkg::REQ_TICK:  op = ast_pkg::OP_TICK;
      ast_pkg::REQ_END:   op = ast_pkg::OP_END;
      ast_pkg::REQ_QUERY: op = ast_pkg::OP_QUERY;
      default:            op = ast_pkg::OP_IGNORE;
    endcase
    // handles past the record store become ignored requests that touch no state
    if ((op inside {ast_pkg::OP_BEGIN, ast_pkg::OP_TICK, ast_pkg::OP_END}) &&
        (int'(scope_handle_i) >= int'(NUM_HANDLES))) begin
      op = ast_pkg::OP_IGNORE;
    end
    req_in.op     = op;
    req_in.handle = scope_handle_i;
    req_in.now    = now_us_i;
  end

  ast_fifo #(
    .item_t (ast_pkg::req_t),
    .DEPTH  (ast_pkg::REQ_QUEUE_DEPTH)
  ) u_req_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (req_in),
    .full_o  (full_o),
    .pop_i   (req_pop_i),
    .data_o  (req_o),
    .empty_o (queue_empty)
  );

  assign req_valid_o = !queue_empty;

endmodule

// File: design/ast_back.sv
module ast_back #(
  parameter int unsigned TABLE_SLOTS = ast_pkg::DEF_TABLE_SLOTS,
  parameter int unsigned NUM_HANDLES = ast_pkg::DEF_NUM_HANDLES,
  parameter int unsigned TIME_BITS   = ast_pkg::DEF_TIME_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ast_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ast_pkg::CFG_W-1:0]      cfg_data_i,
  input  ast_pkg::req_t                  req_i,
  input  logic                           req_valid_i,
  output logic                           req_pop_o,
  output ast_pkg::res_t                  res_o,
  output logic                           res_push_o,
  input  logic                           res_full_i
);

  localparam int unsigned NOW_W  = ast_pkg::NOW_W;
  localparam int unsigned HIDX_W = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
  localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned OCC_W  = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned EL_W   = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  ast_pkg::st_e st_q, st_d;

  // request being worked on
  ast_pkg::op_e                   op_q;
  logic [ast_pkg::HANDLE_W-1:0]   hdl_q;
  logic [NOW_W-1:0]               now_q;

  // per-handle records
  ast_pkg::rec_t                  rec_mem [NUM_HANDLES];
  ast_pkg::rec_t                  rd_rec_q, wr_rec;
  logic                           mem_we;
  logic [HIDX_W-1:0]              rd_idx, h_idx;
  logic [NUM_HANDLES-1:0]         reg_q;

  // slot table, each slot carries a copy of its owner's last tick time
  logic [TABLE_SLOTS-1:0]         slot_valid_q;
  logic [ast_pkg::HANDLE_W-1:0]   slot_owner_q [TABLE_SLOTS];
  logic [NOW_W-1:0]               slot_tick_q  [TABLE_SLOTS];
  logic [OCC_W-1:0]               occ_q, occ_d;

  logic [ast_pkg::CFG_W-1:0]      tick_ivl_q, act_win_q;

  // query scan accumulators
  logic [SLOT_W-1:0]              scan_cnt_q;
  logic                           act_q, act_d, found_q, found_d;
  logic [NOW_W-1:0]               nwin_q, nwin_d, nany_q, nany_d;
  logic [ast_pkg::HANDLE_W-1:0]   who_q, who_d;

  logic                           free_found, own_found;
  logic [SLOT_W-1:0]              free_sel, own_sel;
  logic                           is_reg, claim, release_slot;
  logic                           tick_emit;
  logic [NOW_W-1:0]               tick_gap, span, elapsed_out;
  logic [ast_pkg::CNT_W-1:0]      cnt_next;
  logic                           sc_inwin;
  logic                           age_ok;
  logic [NOW_W-1:0]               age_num;
  logic                           div_start, div_done;
  logic [ast_pkg::AGE_W-1:0]      div_quot;

  assign rd_idx = HIDX_W'(req_i.handle);
  assign h_idx  = HIDX_W'(hdl_q);
  assign is_reg = reg_q[h_idx];

  // slot search: first free slot for begin, lowest slot of the handle for end
  always_comb begin
    free_found = 1'b0;
    free_sel   = '0;
    own_found  = 1'b0;
    own_sel    = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (!free_found && !slot_valid_q[i]) begin
        free_found = 1'b1;
        free_sel   = SLOT_W'(i);
      end
      if (!own_found && slot_valid_q[i] && (slot_owner_q[i] == hdl_q)) begin
        own_found = 1'b1;
        own_sel   = SLOT_W'(i);
      end
    end
  end

  assign claim        = (op_q == ast_pkg::OP_BEGIN) && free_found;
  assign release_slot = (op_q == ast_pkg::OP_END) && is_reg && own_found;

  assign tick_gap  = now_q - rd_rec_q.last_tick;
  assign tick_emit = (now_q >= rd_rec_q.last_tick) &&
                     (tick_gap >= NOW_W'(tick_ivl_q));
  assign cnt_next  = (&rd_rec_q.tick_cnt) ? rd_rec_q.tick_cnt
                                          : rd_rec_q.tick_cnt + ast_pkg::CNT_W'(1);
  assign span        = now_q - rd_rec_q.begin_time;
  assign elapsed_out = NOW_W'(span[EL_W-1:0]);

  always_comb begin
    occ_d = occ_q;
    if (claim) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (release_slot) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  always_comb begin
    wr_rec = rd_rec_q;
    if (op_q == ast_pkg::OP_BEGIN) begin
      wr_rec.begin_time = now_q;
      wr_rec.last_tick  = now_q;
      wr_rec.tick_cnt   = '0;
    end else begin
      wr_rec.last_tick  = now_q;
      wr_rec.tick_cnt   = cnt_next;
    end
  end

  // scan step looks at slot 0; while scanning, the table rotates by one slot per cycle
  assign sc_inwin = (slot_tick_q[0] > now_q) ||
                    ((now_q - slot_tick_q[0]) <= NOW_W'(act_win_q));

  always_comb begin
    act_d   = act_q;
    nwin_d  = nwin_q;
    nany_d  = nany_q;
    who_d   = who_q;
    found_d = found_q;
    if (slot_valid_q[0]) begin
      if (sc_inwin) begin
        act_d = 1'b1;
        if (slot_tick_q[0] > nwin_q) begin
          nwin_d = slot_tick_q[0];
        end
      end
      // strict compare keeps the lowest slot on ties
      if (slot_tick_q[0] > nany_q) begin
        nany_d  = slot_tick_q[0];
        who_d   = slot_owner_q[0];
        found_d = 1'b1;
      end
    end
  end

  assign age_ok  = act_q && (nwin_q != '0) && (now_q >= nwin_q);
  assign age_num = age_ok ? (now_q - nwin_q) : '0;

  ast_sec_div u_sec_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (age_num),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ast_pkg::ST_IDLE: begin
        if (req_valid_i && !res_full_i) begin
          st_d = (req_i.op == ast_pkg::OP_QUERY) ? ast_pkg::ST_SCAN : ast_pkg::ST_EXEC;
        end
      end
      ast_pkg::ST_EXEC: st_d = ast_pkg::ST_IDLE;
      ast_pkg::ST_SCAN: begin
        if (scan_cnt_q == LAST_SLOT) begin
          st_d = ast_pkg::ST_AGE;
        end
      end
      ast_pkg::ST_AGE: st_d = ast_pkg::ST_DIV;
      ast_pkg::ST_DIV: begin
        if (div_done) begin
          st_d = ast_pkg::ST_IDLE;
        end
      end
      default: st_d = ast_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_pop_o  = 1'b0;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    case (st_q)
      ast_pkg::ST_IDLE: req_pop_o = req_valid_i && !res_full_i;
      ast_pkg::ST_EXEC: begin
        mem_we     = (op_q == ast_pkg::OP_BEGIN) || (op_q == ast_pkg::OP_TICK);
        res_push_o = 1'b1;
        res_o.occupied_slots = ast_pkg::OCC_OUT_W'(occ_d);
        case (op_q)
          ast_pkg::OP_BEGIN: begin
            res_o.emitted    = 1'b1;
            res_o.registered = free_found;
          end
          ast_pkg::OP_TICK: begin
            res_o.emitted    = tick_emit;
            res_o.elapsed_us = elapsed_out;
            res_o.tick_total = cnt_next;
          end
          ast_pkg::OP_END: begin
            res_o.emitted    = 1'b1;
            res_o.elapsed_us = elapsed_out;
            res_o.tick_total = rd_rec_q.tick_cnt;
          end
          default: ;
        endcase
      end
      ast_pkg::ST_SCAN: ;
      ast_pkg::ST_AGE:  div_start = 1'b1;
      ast_pkg::ST_DIV: begin
        res_push_o           = div_done;
        res_o.active         = act_q;
        res_o.tick_age_sec   = div_quot;
        res_o.recent_handle  = who_q;
        res_o.recent_found   = found_q;
        res_o.occupied_slots = ast_pkg::OCC_OUT_W'(occ_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ast_pkg::ST_IDLE;
      reg_q        <= '0;
      slot_valid_q <= '0;
      occ_q        <= '0;
      tick_ivl_q   <= ast_pkg::TICK_INTERVAL_RESET;
      act_win_q    <= ast_pkg::ACTIVE_WINDOW_RESET;
      scan_cnt_q   <= '0;
      act_q        <= 1'b0;
      found_q      <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        case (ast_pkg::cfg_reg_e'(cfg_index_i))
          ast_pkg::CFG_TICK_INTERVAL: tick_ivl_q <= cfg_data_i;
          ast_pkg::CFG_ACTIVE_WINDOW: act_win_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (req_pop_o) begin
        scan_cnt_q <= '0;
        act_q      <= 1'b0;
        found_q    <= 1'b0;
      end
      if (st_q == ast_pkg::ST_EXEC) begin
        occ_q <= occ_d;
        if (op_q == ast_pkg::OP_BEGIN) begin
          reg_q[h_idx] <= free_found;
        end else if (op_q == ast_pkg::OP_END) begin
          reg_q[h_idx] <= 1'b0;
        end
        if (claim) begin
          slot_valid_q[free_sel] <= 1'b1;
        end
        if (release_slot) begin
          slot_valid_q[own_sel] <= 1'b0;
        end
      end else if (st_q == ast_pkg::ST_SCAN) begin
        scan_cnt_q <= scan_cnt_q + SLOT_W'(1);
        act_q      <= act_d;
        found_q    <= found_d;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          slot_valid_q[i] <= slot_valid_q[(i == TABLE_SLOTS - 1) ? 0 : i + 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      op_q   <= req_i.op;
      hdl_q  <= req_i.handle;
      now_q  <= req_i.now;
      nwin_q <= '0;
      nany_q <= '0;
      who_q  <= '0;
    end
    if (st_q == ast_pkg::ST_EXEC) begin
      if ((op_q == ast_pkg::OP_BEGIN) || (op_q == ast_pkg::OP_TICK)) begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (slot_valid_q[i] && (slot_owner_q[i] == hdl_q)) begin
            slot_tick_q[i] <= now_q;
          end
        end
      end
      if (claim) begin
        slot_owner_q[free_sel] <= hdl_q;
        slot_tick_q[free_sel]  <= now_q;
      end
    end else if (st_q == ast_pkg::ST_SCAN) begin
      nwin_q <= nwin_d;
      nany_q <= nany_d;
      who_q  <= who_d;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_owner_q[i] <= slot_owner_q[(i == TABLE_SLOTS - 1) ? 0 : i + 1];
        slot_tick_q[i]  <= slot_tick_q[(i == TABLE_SLOTS - 1) ? 0 : i + 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rec_mem[h_idx] <= wr_rec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      rd_rec_q <= rec_mem[rd_idx];
    end
  end

endmodule

// File: design/activity_scope_table.sv
// Scope tracker behind two small request/result queues. Begin, tick and end
// requests, once at the head of the request queue and with room in the
// result queue, are taken in the idle state, which reads the handle's record
// from the record memory; the execute state then updates the record and the
// slot table and queues the result. A query is taken, the slot table is
// walked one slot per cycle, the seconds conversion is started, and then the
// age of the newest in-window tick is turned into seconds by a reciprocal
// multiply in two halves, a remainder check and a one-step correction.
// Every request gives exactly one result.
// Configuration writes are always ready and must only be issued while no
// request is in flight. Tick and end on a handle that never saw a begin read
// an unwritten record and return undefined elapsed time and count (and emit, for a tick).
module activity_scope_table #(
  parameter int unsigned TABLE_SLOTS = ast_pkg::DEF_TABLE_SLOTS,
  parameter int unsigned NUM_HANDLES = ast_pkg::DEF_NUM_HANDLES,
  parameter int unsigned TIME_BITS   = ast_pkg::DEF_TIME_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // requests
  input  logic                            push,
  output logic                            full,
  input  logic [ast_pkg::REQ_W-1:0]       req_type_i,
  input  logic [ast_pkg::HANDLE_W-1:0]    scope_handle_i,
  input  logic [ast_pkg::NOW_W-1:0]       now_us_i,
  // results
  output logic                            empty,
  input  logic                            pop,
  output logic                            emitted_o,
  output logic                            registered_o,
  output logic [ast_pkg::NOW_W-1:0]       elapsed_us_o,
  output logic [ast_pkg::CNT_W-1:0]       tick_total_o,
  output logic                            active_o,
  output logic [ast_pkg::AGE_W-1:0]       tick_age_sec_o,
  output logic [ast_pkg::HANDLE_W-1:0]    recent_handle_o,
  output logic                            recent_found_o,
  output logic [ast_pkg::OCC_OUT_W-1:0]   occupied_slots_o,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ast_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ast_pkg::CFG_W-1:0]       cfg_data_i
);

  ast_pkg::req_t req;
  logic          req_valid, req_pop;
  ast_pkg::res_t res_in, res_out;
  logic          res_push, res_full;

  assign cfg_ready = 1'b1;

  ast_front #(
    .NUM_HANDLES (NUM_HANDLES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .req_type_i     (req_type_i),
    .scope_handle_i (scope_handle_i),
    .now_us_i       (now_us_i),
    .req_o          (req),
    .req_valid_o    (req_valid),
    .req_pop_i      (req_pop)
  );

  ast_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .NUM_HANDLES (NUM_HANDLES),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid && cfg_ready),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req),
    .req_valid_i (req_valid),
    .req_pop_o   (req_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  ast_fifo #(
    .item_t (ast_pkg::res_t),
    .DEPTH  (ast_pkg::RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign emitted_o        = res_out.emitted;
  assign registered_o     = res_out.registered;
  assign elapsed_us_o     = res_out.elapsed_us;
  assign tick_total_o     = res_out.tick_total;
  assign active_o         = res_out.active;
  assign tick_age_sec_o   = res_out.tick_age_sec;
  assign recent_handle_o  = res_out.recent_handle;
  assign recent_found_o   = res_out.recent_found;
  assign occupied_slots_o = res_out.occupied_slots;

endmodule

// File: tb/sv/tb_activity_scope_table.sv
module tb_activity_scope_table;
  timeunit 1ns;
  timeprecision 1ps;

  import ast_pkg::*;

  localparam int SLOTS   = DEF_TABLE_SLOTS;
  localparam int HANDLES = DEF_NUM_HANDLES;
  localparam int LONG_STALL = 300;

  typedef struct {
    req_type_e           rq;
    logic [HANDLE_W-1:0] handle;
    logic [NOW_W-1:0]    now;
  } scope_req_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic [REQ_W-1:0]     req_type_i = '0;
  logic [HANDLE_W-1:0]  scope_handle_i = '0;
  logic [NOW_W-1:0]     now_us_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 emitted_o;
  logic                 registered_o;
  logic [NOW_W-1:0]     elapsed_us_o;
  logic [CNT_W-1:0]     tick_total_o;
  logic                 active_o;
  logic [AGE_W-1:0]     tick_age_sec_o;
  logic [HANDLE_W-1:0]  recent_handle_o;
  logic                 recent_found_o;
  logic [OCC_OUT_W-1:0] occupied_slots_o;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  // shadow copy of the scope records and the slot table
  bit [NOW_W-1:0]    begin_mem     [HANDLES];
  bit [NOW_W-1:0]    last_tick_mem [HANDLES];
  bit [CNT_W-1:0]    tick_cnt_mem  [HANDLES];
  bit                listed_mem    [HANDLES];
  bit [HANDLE_W-1:0] slot_owner_mem [SLOTS];
  bit                slot_used      [SLOTS];
  bit [CFG_W-1:0]    emit_gap_us = TICK_INTERVAL_RESET;
  bit [CFG_W-1:0]    win_len_us  = ACTIVE_WINDOW_RESET;

  // stimulus side: handles whose record has been written by a begin
  bit                handle_begun [HANDLES];
  logic [NOW_W-1:0]  t_now = '0;

  scope_req_t req_pending_q[$];
  res_t       exp_results_q[$];

  int  err_cnt = 0;
  bit  idle_on = 1'b1;
  bit  long_stall_req = 1'b0;
  bit  long_stall_taken = 1'b0;
  int  send_wait = 0;
  int  rx_wait = 0;

  activity_scope_table i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .req_type_i          (req_type_i),
    .scope_handle_i      (scope_handle_i),
    .now_us_i            (now_us_i),
    .empty               (empty),
    .pop                 (pop),
    .emitted_o           (emitted_o),
    .registered_o        (registered_o),
    .elapsed_us_o        (elapsed_us_o),
    .tick_total_o        (tick_total_o),
    .active_o            (active_o),
    .tick_age_sec_o      (tick_age_sec_o),
    .recent_handle_o     (recent_handle_o),
    .recent_found_o      (recent_found_o),
    .occupied_slots_o    (occupied_slots_o),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic res_t predict_scope_result(req_type_e rq, logic [HANDLE_W-1:0] h,
                                                logic [NOW_W-1:0] now);
    res_t              r;
    logic [NOW_W-1:0]  prev;
    logic [NOW_W-1:0]  t;
    logic [NOW_W-1:0]  newest_win;
    logic [NOW_W-1:0]  newest_any;
    logic              act;
    logic              fnd;
    logic [HANDLE_W-1:0] who;
    int                occ;
    r = '0;
    case (rq)
      REQ_QUERY: begin
        act = 1'b0;
        fnd = 1'b0;
        who = '0;
        newest_win = '0;
        newest_any = '0;
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_used[s]) begin
            t = last_tick_mem[slot_owner_mem[s]];
            // a tick stamped after now still counts as inside the window
            if (t > now || (now - t) <= NOW_W'(win_len_us)) begin
              act = 1'b1;
              if (t > newest_win) newest_win = t;
            end
            // strict compare: lowest slot wins ties, time zero never wins
            if (t > newest_any) begin
              newest_any = t;
              who = slot_owner_mem[s];
              fnd = 1'b1;
            end
          end
        end
        r.active = act;
        if (act && newest_win != '0 && now >= newest_win)
          r.tick_age_sec = AGE_W'((now - newest_win) / USEC_PER_SEC);
        r.recent_handle = fnd ? who : '0;
        r.recent_found = fnd;
      end
      REQ_BEGIN: begin
        begin_mem[h] = now;
        last_tick_mem[h] = now;
        tick_cnt_mem[h] = '0;
        listed_mem[h] = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
          if (!slot_used[s] && !listed_mem[h]) begin
            slot_used[s] = 1'b1;
            slot_owner_mem[s] = h;
            listed_mem[h] = 1'b1;
          end
        end
        r.emitted = 1'b1;
        r.registered = listed_mem[h];
      end
      REQ_TICK: begin
        prev = last_tick_mem[h];
        last_tick_mem[h] = now;
        if (tick_cnt_mem[h] != '1) tick_cnt_mem[h] = tick_cnt_mem[h] + 1'b1;
        if (now >= prev && (now - prev) >= NOW_W'(emit_gap_us)) r.emitted = 1'b1;
        r.elapsed_us = now - begin_mem[h];
        r.tick_total = tick_cnt_mem[h];
      end
      REQ_END: begin
        r.elapsed_us = now - begin_mem[h];
        if (listed_mem[h]) begin
          // only the lowest slot held by the handle is released
          for (int s = 0; s < SLOTS; s++) begin
            if (listed_mem[h] && slot_used[s] && slot_owner_mem[s] == h) begin
              slot_used[s] = 1'b0;
              listed_mem[h] = 1'b0;
            end
          end
          listed_mem[h] = 1'b0;
        end
        r.emitted = 1'b1;
        r.tick_total = tick_cnt_mem[h];
      end
      default: ;
    endcase
    occ = 0;
    for (int s = 0; s < SLOTS; s++) if (slot_used[s]) occ++;
    r.occupied_slots = OCC_OUT_W'(occ);
    return r;
  endfunction

  // tick and end only ever address a handle whose record was written
  function automatic void add_item(req_type_e rq, logic [HANDLE_W-1:0] h,
                                   logic [NOW_W-1:0] now);
    scope_req_t it;
    if ((rq == REQ_TICK || rq == REQ_END) && !handle_begun[h]) rq = REQ_BEGIN;
    if (rq == REQ_BEGIN) handle_begun[h] = 1'b1;
    it.rq = rq;
    it.handle = h;
    it.now = now;
    req_pending_q.push_back(it);
  endfunction

  function automatic logic [NOW_W-1:0] next_time(logic [NOW_W-1:0] t);
    logic [NOW_W-1:0] span;
    span = NOW_W'(emit_gap_us) + NOW_W'(win_len_us) + NOW_W'(2);
    case ($urandom_range(0, 19))
      0: return t;
      1: return t - NOW_W'($urandom_range(0, 2000));
      2: return NOW_W'({$urandom, $urandom});
      3: return '1 - NOW_W'($urandom_range(0, 3));
      4: return NOW_W'($urandom_range(0, 3));
      5: return t + NOW_W'(emit_gap_us);
      6: return t + NOW_W'(emit_gap_us) - NOW_W'(1);
      7: return t + NOW_W'(win_len_us);
      default: return t + (NOW_W'({$urandom, $urandom}) % span);
    endcase
  endfunction

  function automatic void gen_random(int n);
    logic [HANDLE_W-1:0] h;
    req_type_e           rq;
    int                  pick;
    for (int i = 0; i < n; i++) begin
      t_now = next_time(t_now);
      h = ($urandom_range(0, 3) == 0) ? HANDLE_W'($urandom_range(0, 31))
                                       : HANDLE_W'($urandom_range(0, 11));
      pick = $urandom_range(0, 19);
      if (pick < 4)       rq = REQ_BEGIN;
      else if (pick < 12) rq = REQ_TICK;
      else if (pick < 16) rq = REQ_END;
      else                rq = REQ_QUERY;
      add_item(rq, h, t_now);
    end
  endfunction

  task automatic write_cfg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_TICK_INTERVAL) emit_gap_us = val;
    else win_len_us = val;
  endtask

  task automatic drain(int extra);
    while (req_pending_q.size() != 0 || push || exp_results_q.size() != 0)
      @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
      err_cnt++;
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    scope_req_t it;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full)
        exp_results_q.push_back(predict_scope_result(req_type_e'(req_type_i),
                                                     scope_handle_i, now_us_i));
      if (!(push && full)) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          push <= 1'b0;
        end else if (req_pending_q.size() != 0) begin
          it = req_pending_q.pop_front();
          req_type_i <= it.rq;
          scope_handle_i <= it.handle;
          now_us_i <= it.now;
          push <= 1'b1;
          if (idle_on && $urandom_range(0, 9) == 0) send_wait <= $urandom_range(1, 16);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = {emitted_o, registered_o, elapsed_us_o, tick_total_o, active_o,
               tick_age_sec_o, recent_handle_o, recent_found_o, occupied_slots_o};
        if (exp_results_q.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          err_cnt++;
        end else begin
          want = exp_results_q.pop_front();
          check_field("emitted", 64'(want.emitted), 64'(got.emitted));
          check_field("registered", 64'(want.registered), 64'(got.registered));
          check_field("elapsed_us", 64'(want.elapsed_us), 64'(got.elapsed_us));
          check_field("tick_total", 64'(want.tick_total), 64'(got.tick_total));
          check_field("active", 64'(want.active), 64'(got.active));
          check_field("tick_age_sec", 64'(want.tick_age_sec),
                      64'(got.tick_age_sec));
          check_field("recent_handle", 64'(want.recent_handle), 64'(got.recent_handle));
          check_field("recent_found", 64'(want.recent_found), 64'(got.recent_found));
          check_field("occupied_slots", 64'(want.occupied_slots),
                      64'(got.occupied_slots));
        end
      end
      if (long_stall_req && !long_stall_taken) begin
        long_stall_taken <= 1'b1;
        rx_wait <= LONG_STALL;
        pop <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        rx_wait <= $urandom_range(0, 15);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset configuration
    add_item(REQ_QUERY, 5'd0, 48'd0);
    add_item(REQ_BEGIN, 5'd0, 48'd0);
    add_item(REQ_QUERY, 5'd0, 48'd0);
    add_item(REQ_TICK, 5'd0, 48'd0);
    add_item(REQ_TICK, 5'd0, 48'd30_000_000);
    add_item(REQ_TICK, 5'd0, 48'd29_999_999);
    add_item(REQ_TICK, 5'd0, 48'd59_999_998);
    add_item(REQ_QUERY, 5'd0, 48'd119_999_998);
    add_item(REQ_QUERY, 5'd0, 48'd119_999_999);
    for (int i = 1; i <= 8; i++) add_item(REQ_BEGIN, HANDLE_W'(i), 48'd1000);
    add_item(REQ_END, 5'd3, 48'd5000);
    add_item(REQ_BEGIN, 5'd1, 48'd6000);
    add_item(REQ_END, 5'd1, 48'd7000);
    add_item(REQ_QUERY, 5'd0, 48'd3000);
    add_item(REQ_BEGIN, 5'd31, '1);
    add_item(REQ_TICK, 5'd31, 48'd5);
    add_item(REQ_QUERY, 5'd0, '1);
    add_item(REQ_END, 5'd8, 48'd9000);
    add_item(REQ_TICK, 5'd2, 48'hAAAA_AAAA_AAAA);
    drain(50);

    write_cfg(CFG_TICK_INTERVAL, '0);
    write_cfg(CFG_ACTIVE_WINDOW, '0);
    gen_random(200);
    drain(50);

    idle_on = 1'b0;
    write_cfg(CFG_TICK_INTERVAL, '1);
    write_cfg(CFG_ACTIVE_WINDOW, '1);
    gen_random(150);
    drain(50);

    // receiver holds off while requests keep coming
    idle_on = 1'b1;
    write_cfg(CFG_TICK_INTERVAL, 32'd2000);
    write_cfg(CFG_ACTIVE_WINDOW, 32'd5000);
    long_stall_req <= 1'b1;
    gen_random(200);
    drain(50);

    write_cfg(CFG_TICK_INTERVAL, CFG_W'($urandom_range(0, 100_000_000)));
    write_cfg(CFG_ACTIVE_WINDOW, CFG_W'($urandom_range(0, 100_000_000)));
    gen_random(150);
    drain(50);

    idle_on = 1'b0;
    write_cfg(CFG_TICK_INTERVAL, TICK_INTERVAL_RESET);
    write_cfg(CFG_ACTIVE_WINDOW, ACTIVE_WINDOW_RESET);
    gen_random(100);
    drain(60);

    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
